FILE: hdl/wdnr_pkg.sv
// Package for wide_decimal_narrow_round: sequencer states, status codes and
// the constants of the divide-by-ten step. No dependencies.
package wdnr_pkg;

  localparam int MAX_SCALE_DEF = 28;

  localparam int WIDE_W  = 192;
  localparam int NARR_W  = 96;
  localparam int WORD_W  = 32;
  localparam int NWORDS  = WIDE_W / WORD_W;
  localparam int SCALE_W = 7;

  // 2^32 = 429496729 * 10 + 6
  localparam logic [31:0] TWO32_DIV10 = 32'd429496729;
  localparam logic [2:0]  TWO32_MOD10 = 3'd6;

  // ceil(2^36 / 10): exact quotient for operands below 2^34
  localparam int          RECIP_SH = 36;
  localparam logic [32:0] RECIP10  = 33'd6871947674;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_POS_OVF = 2'd1;
  localparam logic [1:0] ST_NEG_OVF = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_DONE
  } state_t;

endpackage

FILE: hdl/wide_decimal_narrow_round.sv
// Top level of wide_decimal_narrow_round: sequencer around one shared
// divide-by-ten unit that works through the 192-bit mantissa a word a cycle.
// Depends on wdnr_pkg.
//
// Narrows a 192-bit unsigned decimal mantissa with a 6-bit scale to a 96-bit
// mantissa with scale 0..MAX_SCALE, rounding half up on the last discarded
// digit; a negative scale or a rounding carry out of 96 bits gives an overflow
// status with zero result fields. One item at a time: in_tready is high only
// while the sequencer is idle. At most 35 divisions by ten are made per item.
// After the input transfer the sequencer checks, divides as needed and loads
// the result as it returns to idle to take the next input. Each division is
// a check state and then a word step for each of the six 32-bit words, which
// use the one reciprocal multiplier. A finished result sits in the output
// register, so the next item may be taken while it waits; the sequencer only
// stalls when a new result is ready and the previous one is still waiting.
module wide_decimal_narrow_round
  import wdnr_pkg::*;
#(
  parameter int MAX_SCALE = MAX_SCALE_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // value_low[63:0], value_mid[127:64], value_high[191:128], scale_in[197:192],
  // negative[198], zero fill[199]
  input  logic [199:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // mantissa_low[63:0], mantissa_high[95:64], scale_out[100:96],
  // negative_out[101], status[103:102]
  output logic [103:0] out_tdata
);

  localparam logic signed [SCALE_W-1:0] MAX_SC = SCALE_W'(MAX_SCALE);
  localparam logic [2:0] LAST_WORD = 3'(NWORDS - 1);

  state_t state_r, state_nxt;

  logic [WIDE_W-1:0]         w_r, w_nxt;
  logic signed [SCALE_W-1:0] scale_r, scale_nxt;
  logic                      neg_r, neg_nxt;
  logic [3:0]                rem_r, rem_nxt;
  logic [3:0]                last_rem_r, last_rem_nxt;
  logic [2:0]                cnt_r, cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [103:0]              out_data_r, out_data_nxt;

  logic              need_div;
  logic              out_free;
  logic [32:0]       div_num;
  logic [65:0]       div_prod;
  logic [28:0]       div_q1;
  logic [32:0]       div_back;
  logic [WORD_W-1:0] div_q;
  logic [3:0]        div_rem;
  logic [NARR_W:0]   rnd_sum;
  logic              ovf;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  assign need_div = (w_r[WIDE_W-1:NARR_W] != '0) || (scale_r > MAX_SC);

  // shared divide-by-ten unit: (rem * 2^32 + word) / 10
  assign div_num  = {1'b0, w_r[WIDE_W-1 -: WORD_W]} +
                    33'({2'b00, rem_r} * 6'(TWO32_MOD10));
  assign div_prod = 66'(div_num) * 66'(RECIP10);
  assign div_q1   = div_prod[RECIP_SH+28:RECIP_SH];
  assign div_back = div_num - 33'(div_q1) * 33'(4'd10);
  assign div_rem  = div_back[3:0];
  assign div_q    = 32'(rem_r) * TWO32_DIV10 + 32'(div_q1);

  assign rnd_sum = {1'b0, w_r[NARR_W-1:0]} + (NARR_W+1)'(last_rem_r >= 4'd5);
  assign ovf     = (scale_r < 0) || rnd_sum[NARR_W];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_CHECK;
      S_CHECK: state_nxt = need_div ? S_DIV : S_DONE;
      S_DIV:   if (cnt_r == LAST_WORD) state_nxt = S_CHECK;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    w_nxt         = w_r;
    scale_nxt     = scale_r;
    neg_nxt       = neg_r;
    rem_nxt       = rem_r;
    last_rem_nxt  = last_rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          w_nxt        = in_tdata[WIDE_W-1:0];
          scale_nxt    = {1'b0, in_tdata[197:192]};
          neg_nxt      = in_tdata[198];
          last_rem_nxt = '0;
        end
      end
      S_CHECK: begin
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      S_DIV: begin
        w_nxt   = {w_r[WIDE_W-WORD_W-1:0], div_q};
        rem_nxt = div_rem;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == LAST_WORD) begin
          last_rem_nxt = div_rem;
          scale_nxt    = scale_r - SCALE_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (ovf) begin
            out_data_nxt = {(neg_r ? ST_NEG_OVF : ST_POS_OVF), 102'd0};
          end else begin
            out_data_nxt = {ST_OK, neg_r, scale_r[4:0], rnd_sum[NARR_W-1:0]};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    w_r        <= w_nxt;
    scale_r    <= scale_nxt;
    neg_r      <= neg_nxt;
    rem_r      <= rem_nxt;
    last_rem_r <= last_rem_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[103:102] != ST_OK) |-> out_tdata[101:0] == '0)
    else $error("overflow result with non-zero fields");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[103:102] != 2'd3)
    else $error("undefined status code");

  a_div_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && (cnt_r != LAST_WORD) |=> (state_r == S_DIV))
    else $error("division pass cut short");

  a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[103:102] == ST_OK) |->
      (MAX_SCALE > 31) || (32'(out_tdata[100:96]) <= 32'(MAX_SCALE)))
    else $error("result scale above limit");

endmodule

FILE: verif/tb_wide_decimal_narrow_round.sv
// Testbench for wide_decimal_narrow_round: directed extreme, rounding, scale-limit and
// drain cases, then a random mix of magnitudes and scales, checked by an in-bench rescale predictor.
// Depends on wdnr_pkg and the wide_decimal_narrow_round RTL.
module tb_wide_decimal_narrow_round
  import wdnr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LIMIT_CYCLES = 1_500_000;
  localparam int          TAIL_CYCLES  = 300;
  localparam int          RANDOM_ITEMS = 1400;
  localparam logic [191:0] ONE96  = 192'd1 << 96;
  localparam logic [191:0] ALL96  = (192'd1 << 96) - 192'd1;
  localparam logic [191:0] ALL192 = {192{1'b1}};

  // same bit order as out_tdata
  typedef struct packed {
    logic [1:0]  status;
    logic        neg;
    logic [4:0]  scale;
    logic [31:0] hi;
    logic [63:0] lo;
  } narrow_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [199:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;

  narrow_t expected_narrowed[$];
  int      mismatches;
  int      cycles;
  bit      in_steady;
  bit      out_steady;

  wide_decimal_narrow_round uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic narrow_t rescale_to_96(logic [191:0] mant, logic [5:0] sc, logic neg);
    narrow_t      r;
    logic [191:0] w;
    logic [3:0]   digit;
    logic [96:0]  rounded;
    int           s;
    w = mant;
    s = int'(sc);
    digit = '0;
    r = '0;
    while (w[191:96] != '0) begin
      digit = 4'(w % 192'd10);
      w = w / 192'd10;
      s--;
    end
    while (s > MAX_SCALE_DEF) begin
      digit = 4'(w % 192'd10);
      w = w / 192'd10;
      s--;
    end
    if (s < 0) begin
      r.status = neg ? ST_NEG_OVF : ST_POS_OVF;
    end else begin
      rounded = {1'b0, w[95:0]} + ((digit >= 4'd5) ? 97'd1 : 97'd0);
      if (rounded[96]) begin
        r.status = neg ? ST_NEG_OVF : ST_POS_OVF;
      end else begin
        r.lo = rounded[63:0];
        r.hi = rounded[95:64];
        r.scale = 5'(s);
        r.neg = neg;
        r.status = ST_OK;
      end
    end
    return r;
  endfunction

  task automatic send_item(input logic [191:0] mant, input logic [5:0] sc, input logic neg);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, neg, sc, mant};
    do @(posedge clk); while (!in_tready);
    expected_narrowed.push_back(rescale_to_96(mant, sc, neg));
  endtask

  // input side goes idle, then waits for every outstanding result
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_narrowed.size() != 0) @(posedge clk);
  endtask

  function automatic logic [191:0] rand_wide();
    logic [191:0] v;
    for (int i = 0; i < 6; i++) v[32*i +: 32] = $urandom;
    return v;
  endfunction

  task automatic test_extremes();
    send_item('0, 6'd0, 1'b0);
    send_item('0, 6'd0, 1'b1);
    send_item('0, 6'd63, 1'b1);
    send_item(ALL192, 6'd63, 1'b1);
    send_item(ALL192, 6'd0, 1'b0);
    send_item(ALL192, 6'd0, 1'b1);
    send_item(ALL96, 6'd0, 1'b0);
    send_item(ALL96, 6'd0, 1'b1);
    send_item(ONE96, 6'd0, 1'b0);
    send_item(ONE96, 6'd0, 1'b1);
    send_item(ONE96, 6'd1, 1'b0);
  endtask

  task automatic test_rounding();
    send_item(ALL96 * 192'd10 + 192'd4, 6'd1, 1'b0);
    send_item(ALL96 * 192'd10 + 192'd5, 6'd1, 1'b0);
    send_item(ALL96 * 192'd10 + 192'd9, 6'd5, 1'b1);
    send_item(ALL96 * 192'd10 + 192'd5, 6'd0, 1'b1);
    send_item(192'd125, 6'd30, 1'b0);
    send_item(192'd149, 6'd29, 1'b1);
    send_item(192'd144, 6'd29, 1'b0);
  endtask

  task automatic test_scale_limit();
    send_item(192'd7, 6'd28, 1'b0);
    send_item(192'd7, 6'd29, 1'b1);
    send_item(192'd7, 6'd63, 1'b0);
    send_item('0, 6'd63, 1'b0);
  endtask

  // sender holds off until the block and the result side are empty
  task automatic test_drain();
    wait_drained();
    send_item(rand_wide(), 6'd63, 1'b1);
  endtask

  task automatic test_random_mix();
    logic [191:0] m;
    logic [5:0]   sc;
    int           kind;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) in_steady = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      sc = 6'($urandom_range(0, 63));
      case (kind)
        0, 1, 2, 3: begin
          m = rand_wide() >> $urandom_range(0, 191);
        end
        4, 5: begin
          m = rand_wide() >> (96 + $urandom_range(0, 95));
        end
        6: begin
          m = (ALL96 - 192'($urandom_range(0, 3))) * 192'd10 + 192'($urandom_range(0, 9));
        end
        7: begin
          m = ONE96 - 192'd2 + 192'($urandom_range(0, 3));
          repeat ($urandom_range(0, 3)) m = m * 192'd10;
          m = m + 192'($urandom_range(0, 9));
          sc = 6'($urandom_range(0, 40));
        end
        8: begin
          m = 192'($urandom_range(0, 15));
        end
        default: begin
          m = rand_wide();
          sc = 6'($urandom_range(25, 35));
        end
      endcase
      send_item(m, sc, 1'($urandom_range(0, 1)));
    end
    in_steady = 1'b0;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_narrowed.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    narrow_t got;
    narrow_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got = narrow_t'(out_tdata);
      if (expected_narrowed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: st=%0d neg=%0b sc=%0d man=%h_%h", got.status,
                   got.neg, got.scale, got.hi, got.lo);
      end else begin
        exp_r = expected_narrowed.pop_front();
        if (got.lo !== exp_r.lo || got.hi !== exp_r.hi || got.scale !== exp_r.scale ||
            got.neg !== exp_r.neg || got.status !== exp_r.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d n=%0b sc=%0d m=%h_%h got st=%0d n=%0b sc=%0d m=%h_%h",
                     exp_r.status, exp_r.neg, exp_r.scale, exp_r.hi, exp_r.lo,
                     got.status, got.neg, got.scale, got.hi, got.lo);
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    int stall;
    int taken;
    taken = 0;
    forever begin
      @(negedge clk);
      if (taken % 150 == 0) out_steady = ($urandom_range(0, 3) == 0);
      stall = out_steady ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    mismatches = 0;
    cycles     = 0;
    in_steady  = 1'b0;
    out_steady = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_rounding();
    test_scale_limit();
    test_drain();
    test_random_mix();

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_narrowed.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
